// ===== design/bsvf_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the biquad to svf coefficient converter
// no dependencies
package bsvf_pkg;

   // restoring square root retires two radicand bits per step
   localparam int unsigned SQRT_DIGIT_BITS = 2;
   localparam logic [SQRT_DIGIT_BITS-1:0] SQRT_TRIAL_TAIL = 2'b01;

   // fault and clip flags that travel with an item
   typedef struct packed {
      logic fault;
      logic sat;
   } status_type;

endpackage

// ===== design/bsvf_req_if.sv =====
`timescale 1ns / 1ps
// request and response channels: valid/ready handshake with coefficient payloads
// no dependencies
interface bsvf_req_if #(parameter int COEF_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] coef_b0;
   logic signed [COEF_WIDTH-1:0] coef_b1;
   logic signed [COEF_WIDTH-1:0] coef_b2;
   logic signed [COEF_WIDTH-1:0] coef_a1;
   logic signed [COEF_WIDTH-1:0] coef_a2;
   modport source (output valid, coef_b0, coef_b1, coef_b2, coef_a1, coef_a2, input ready);
   modport sink   (input valid, coef_b0, coef_b1, coef_b2, coef_a1, coef_a2, output ready);
endinterface

interface bsvf_rsp_if #(parameter int COEF_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] gain_g;
   logic signed [COEF_WIDTH-1:0] damping_r2;
   logic signed [COEF_WIDTH-1:0] damping_plus_gain;
   logic signed [COEF_WIDTH-1:0] feedback_scale_h;
   logic signed [COEF_WIDTH-1:0] mix_lowpass;
   logic signed [COEF_WIDTH-1:0] mix_bandpass;
   logic signed [COEF_WIDTH-1:0] mix_highpass;
   logic                         divide_fault;
   logic                         saturated;
   modport source (output valid, gain_g, damping_r2, damping_plus_gain, feedback_scale_h,
                   mix_lowpass, mix_bandpass, mix_highpass, divide_fault, saturated,
                   input ready);
   modport sink   (input valid, gain_g, damping_r2, damping_plus_gain, feedback_scale_h,
                   mix_lowpass, mix_bandpass, mix_highpass, divide_fault, saturated,
                   output ready);
endinterface

// ===== design/biquad_to_svf_coefficients_top.sv =====
`timescale 1ns / 1ps
// biquad to state variable filter coefficient converter, top level
// depends on bsvf_pkg, bsvf_req_if/bsvf_rsp_if, bsvf_sqrt, bsvf_div
// path from accept to result: stages 1 and 2, the root pipeline, the five parallel quotient pipelines,
//   stages R, M and D, the h quotient pipeline and the output register
// throughput: one item per cycle; the whole pipe advances whenever the output register
//   is empty or being taken, so req ready follows rsp ready
// reset: synchronous, clears every stage valid bit; payload registers are not reset
module biquad_to_svf_coefficients_top #(
   parameter int COEF_WIDTH = 32,
   parameter int FRAC_BITS  = 24
) (
   input  logic         clock,
   input  logic         reset,
   bsvf_req_if.sink     req_chan,
   bsvf_rsp_if.source   rsp_chan
);
   import bsvf_pkg::*;

   localparam int W   = COEF_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int UW  = W + 2;          // u1, u2, numerators, denominators
   localparam int PW  = 2 * UW;         // u1*u2 product
   localparam int NW  = UW + F;         // first divider numerator and quotient
   localparam int MW  = 2 * W;          // R2pg*g product
   localparam int TW  = MW - F;         // truncated product
   localparam int DW2 = TW + 1;         // h divisor
   localparam int NW2 = 2 * F + 1;      // h numerator
   localparam int QW  = (NW > NW2) ? NW : NW2;
   localparam int LAT = 2 + UW + NW + 3 + NW2 + 1;

   localparam logic signed [UW-1:0] ONE_U  = UW'(1) << F;
   localparam logic [TW-1:0]        ONE_T  = TW'(1) << F;
   localparam logic [NW2-1:0]       H_NUM  = NW2'(1) << (2 * F);
   localparam logic [QW-1:0]        LIM    = QW'(1) << (W - 1);
   localparam logic signed [W-1:0]  MAXV   = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  MINV   = {1'b1, {(W-1){1'b0}}};

   // first stage payload, carried alongside the root pipeline
   typedef struct packed {
      logic [UW-1:0] m2;
      logic          pneg;
      logic [UW-1:0] nr2m;
      logic          nr2n;
      logic [UW-1:0] ncbm;
      logic          ncbn;
      logic [UW-1:0] nchm;
      logic          nchn;
      logic [UW-1:0] nclm;
      logic          ncln;
      logic [UW-1:0] dhm;
      logic          dhn;
      logic [UW-1:0] dlm;
      logic          dln;
   } front_type;

   // signs and zero-divisor flags carried alongside the quotient pipelines
   typedef struct packed {
      logic zg;
      logic zp;
      logic zh;
      logic zl;
      logic r2n;
      logic cbn;
      logic chn;
      logic cln;
   } divsb_type;

   typedef struct packed {
      logic signed [W-1:0] g;
      logic signed [W-1:0] r2;
      logic signed [W-1:0] rpg;
      logic signed [W-1:0] cb;
      logic signed [W-1:0] ch;
      logic signed [W-1:0] cl;
      status_type          st;
   } coef_type;

   typedef struct packed {
      coef_type c;
      logic     dneg;
      logic     zh;
   } hsb_type;

   function automatic logic [UW-1:0] mag_u(input logic signed [UW-1:0] v);
      return v[UW-1] ? UW'(-v) : UW'(v);
   endfunction

   // magnitude quotient to signed field, {clipped, value}
   function automatic logic [W:0] sat_q(input logic neg, input logic [QW-1:0] q);
      logic [QW-1:0] nq;
      nq = -q;
      if (neg) begin
         if (q > LIM) return {1'b1, MINV};
         return {1'b0, nq[W-1:0]};
      end
      if (q > LIM - QW'(1)) return {1'b1, MAXV};
      return {1'b0, q[W-1:0]};
   endfunction

   // stall control: every stage moves together
   logic           en;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   assign en             = !vld_ff[LAT-1] || rsp_chan.ready;
   assign req_chan.ready = en;
   assign vld_in         = {vld_ff[LAT-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: u1, u2, both denominators and the numerators at full width
   logic signed [UW-1:0] b0x, b1x, b2x, a1x, a2x;
   logic signed [UW-1:0] u1, u2, dh, dl, nr2, ncb, nch, ncl;
   front_type            front_in, front_ff;
   logic [UW-1:0]        m1_in, m1_ff;
   logic                 same_in, same_ff;

   assign b0x = UW'(req_chan.coef_b0);
   assign b1x = UW'(req_chan.coef_b1);
   assign b2x = UW'(req_chan.coef_b2);
   assign a1x = UW'(req_chan.coef_a1);
   assign a2x = UW'(req_chan.coef_a2);
   assign u1  = -ONE_U - a1x - a2x;
   assign u2  = -ONE_U + a1x - a2x;
   assign dh  = ONE_U - a1x + a2x;
   assign dl  = ONE_U + a1x + a2x;
   assign nr2 = (a2x - ONE_U) <<< 1;
   assign ncb = (b2x - b0x) <<< 1;
   assign nch = b0x - b1x + b2x;
   assign ncl = b0x + b1x + b2x;

   always_comb begin
      m1_in          = mag_u(u1);
      // both strictly positive or both strictly negative
      same_in        = (!u1[UW-1] && (u1 != '0) && !u2[UW-1] && (u2 != '0))
                    || (u1[UW-1] && u2[UW-1]);
      front_in.m2    = mag_u(u2);
      front_in.pneg  = u1[UW-1];
      front_in.nr2m  = mag_u(nr2);
      front_in.nr2n  = nr2[UW-1];
      front_in.ncbm  = mag_u(ncb);
      front_in.ncbn  = ncb[UW-1];
      front_in.nchm  = mag_u(nch);
      front_in.nchn  = nch[UW-1];
      front_in.nclm  = mag_u(ncl);
      front_in.ncln  = ncl[UW-1];
      front_in.dhm   = mag_u(dh);
      front_in.dhn   = dh[UW-1];
      front_in.dlm   = mag_u(dl);
      front_in.dln   = dl[UW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in;
         m1_ff    <= m1_in;
         same_ff  <= same_in;
      end
   end

   // stage 2: u1*u2 magnitude product, zero when the signs disagree
   logic [PW-1:0] prod_ff;
   front_type     front2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= same_ff ? (PW'(m1_ff) * PW'(front_ff.m2)) : '0;
         front2_ff <= front_ff;
      end
   end

   // root pipeline, payload delayed to match
   logic [UW-1:0] pm;
   front_type     sq_dly_ff [UW];

   bsvf_sqrt #(.ROOT_W(UW)) u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (prod_ff),
      .root  (pm)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sq_dly_ff[0] <= front2_ff;
         for (int i = 1; i < UW; i++) sq_dly_ff[i] <= sq_dly_ff[i-1];
      end
   end

   // five quotients in parallel: g, R2, cB, cH, cL
   front_type     fs;
   divsb_type     dv_in;
   divsb_type     dv_dly_ff [NW];
   logic [NW-1:0] q_g, q_r2, q_cb, q_ch, q_cl;

   assign fs = sq_dly_ff[UW-1];

   always_comb begin
      dv_in.zg  = (fs.m2 == '0);
      dv_in.zp  = (pm == '0);
      dv_in.zh  = (fs.dhm == '0);
      dv_in.zl  = (fs.dlm == '0);
      dv_in.r2n = fs.nr2n ^ fs.pneg;
      dv_in.cbn = fs.ncbn ^ fs.pneg;
      dv_in.chn = fs.nchn ^ fs.dhn;
      dv_in.cln = fs.ncln ^ fs.dln;
   end

   bsvf_div #(.NUM_W(NW), .DEN_W(UW)) u_div_g (
      .clock (clock), .en (en), .num ({pm, {F{1'b0}}}), .den (fs.m2), .quo (q_g));
   bsvf_div #(.NUM_W(NW), .DEN_W(UW)) u_div_r2 (
      .clock (clock), .en (en), .num ({fs.nr2m, {F{1'b0}}}), .den (pm), .quo (q_r2));
   bsvf_div #(.NUM_W(NW), .DEN_W(UW)) u_div_cb (
      .clock (clock), .en (en), .num ({fs.ncbm, {F{1'b0}}}), .den (pm), .quo (q_cb));
   bsvf_div #(.NUM_W(NW), .DEN_W(UW)) u_div_ch (
      .clock (clock), .en (en), .num ({fs.nchm, {F{1'b0}}}), .den (fs.dhm), .quo (q_ch));
   bsvf_div #(.NUM_W(NW), .DEN_W(UW)) u_div_cl (
      .clock (clock), .en (en), .num ({fs.nclm, {F{1'b0}}}), .den (fs.dlm), .quo (q_cl));

   always_ff @(posedge clock) begin
      if (en) begin
         dv_dly_ff[0] <= dv_in;
         for (int i = 1; i < NW; i++) dv_dly_ff[i] <= dv_dly_ff[i-1];
      end
   end

   // stage R: clip the quotients, zero the ones with a zero divisor, form R2+g
   divsb_type           ds;
   logic [W:0]          s_g, s_r2, s_cb, s_ch, s_cl;
   logic signed [W:0]   sum_rg;
   coef_type            coef_in, coef_ff;

   assign ds = dv_dly_ff[NW-1];

   always_comb begin
      s_g    = sat_q(1'b0,   QW'(q_g));
      s_r2   = sat_q(ds.r2n, QW'(q_r2));
      s_cb   = sat_q(ds.cbn, QW'(q_cb));
      s_ch   = sat_q(ds.chn, QW'(q_ch));
      s_cl   = sat_q(ds.cln, QW'(q_cl));
      coef_in.g  = ds.zg ? '0 : s_g[W-1:0];
      coef_in.r2 = ds.zp ? '0 : s_r2[W-1:0];
      coef_in.cb = ds.zp ? '0 : s_cb[W-1:0];
      coef_in.ch = ds.zh ? '0 : s_ch[W-1:0];
      coef_in.cl = ds.zl ? '0 : s_cl[W-1:0];
      coef_in.st.fault = ds.zg || ds.zp || ds.zh || ds.zl;
      sum_rg = (W+1)'(coef_in.r2) + (W+1)'(coef_in.g);
      // overflow of the sum shows as the two top bits disagreeing
      if (sum_rg[W] != sum_rg[W-1]) begin
         coef_in.rpg = sum_rg[W] ? MINV : MAXV;
      end else begin
         coef_in.rpg = sum_rg[W-1:0];
      end
      coef_in.st.sat = (!ds.zg && s_g[W]) || (!ds.zp && (s_r2[W] || s_cb[W]))
                    || (!ds.zh && s_ch[W]) || (!ds.zl && s_cl[W])
                    || (sum_rg[W] != sum_rg[W-1]);
   end

   always_ff @(posedge clock) begin
      if (en) coef_ff <= coef_in;
   end

   // stage M: |R2pg| * g, g is never negative
   logic [W-1:0]  rpg_mag;
   logic [MW-1:0] prod2_ff;
   coef_type      coef_m_ff;

   assign rpg_mag = coef_ff.rpg[W-1] ? W'(-coef_ff.rpg) : W'(coef_ff.rpg);

   always_ff @(posedge clock) begin
      if (en) begin
         prod2_ff  <= MW'(rpg_mag) * MW'(coef_ff.g);
         coef_m_ff <= coef_ff;
      end
   end

   // stage D: truncate and form the magnitude and sign of 1 + R2pg*g
   logic [TW-1:0]  t_mag;
   logic [DW2-1:0] dm_in, dm_ff;
   logic           dneg_in, dneg_ff;
   coef_type       coef_d_ff;

   assign t_mag = prod2_ff[MW-1:F];

   always_comb begin
      if (!coef_m_ff.rpg[W-1]) begin
         dm_in   = DW2'(t_mag) + DW2'(ONE_T);
         dneg_in = 1'b0;
      end else if (t_mag >= ONE_T) begin
         dm_in   = DW2'(t_mag - ONE_T);
         dneg_in = 1'b1;
      end else begin
         dm_in   = DW2'(ONE_T - t_mag);
         dneg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dm_ff     <= dm_in;
         dneg_ff   <= dneg_in;
         coef_d_ff <= coef_m_ff;
      end
   end

   // h quotient pipeline
   logic [NW2-1:0] q_h;
   hsb_type        hsb_dly_ff [NW2];
   hsb_type        hsb_cur;

   always_comb begin
      hsb_cur.c    = coef_d_ff;
      hsb_cur.dneg = dneg_ff;
      hsb_cur.zh   = (dm_ff == '0);
   end

   bsvf_div #(.NUM_W(NW2), .DEN_W(DW2)) u_div_h (
      .clock (clock), .en (en), .num (H_NUM), .den (dm_ff), .quo (q_h));

   always_ff @(posedge clock) begin
      if (en) begin
         hsb_dly_ff[0] <= hsb_cur;
         for (int i = 1; i < NW2; i++) hsb_dly_ff[i] <= hsb_dly_ff[i-1];
      end
   end

   // output register
   hsb_type             hs;
   logic [W:0]          s_h;
   logic signed [W-1:0] h_in, h_ff;
   coef_type            out_in, out_ff;

   assign hs = hsb_dly_ff[NW2-1];

   always_comb begin
      s_h    = sat_q(hs.dneg, QW'(q_h));
      h_in   = hs.zh ? '0 : s_h[W-1:0];
      out_in = hs.c;
      out_in.st.fault = hs.c.st.fault || hs.zh;
      out_in.st.sat   = hs.c.st.sat || (!hs.zh && s_h[W]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
         h_ff   <= h_in;
      end
   end

   assign rsp_chan.valid             = vld_ff[LAT-1];
   assign rsp_chan.gain_g            = out_ff.g;
   assign rsp_chan.damping_r2        = out_ff.r2;
   assign rsp_chan.damping_plus_gain = out_ff.rpg;
   assign rsp_chan.feedback_scale_h  = h_ff;
   assign rsp_chan.mix_lowpass       = out_ff.cl;
   assign rsp_chan.mix_bandpass      = out_ff.cb;
   assign rsp_chan.mix_highpass      = out_ff.ch;
   assign rsp_chan.divide_fault      = out_ff.st.fault;
   assign rsp_chan.saturated         = out_ff.st.sat;
endmodule

// ===== design/bsvf_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, unsigned
// no dependencies
module bsvf_div #(
   parameter int NUM_W = 58,
   parameter int DEN_W = 34
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] n_ff   [NUM_W];
   logic [DEN_W-1:0] d_ff   [NUM_W];
   logic [NUM_W-1:0] q_ff   [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W-1:0] rem_i;
      logic [NUM_W-1:0] n_i;
      logic [DEN_W-1:0] d_i;
      logic [NUM_W-1:0] q_i;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      if (k == 0) begin : g_first
         assign rem_i = '0;
         assign n_i   = num;
         assign d_i   = den;
         assign q_i   = '0;
      end else begin : g_next
         assign rem_i = rem_ff[k-1];
         assign n_i   = n_ff[k-1];
         assign d_i   = d_ff[k-1];
         assign q_i   = q_ff[k-1];
      end
      assign trial  = {rem_i, n_i[NUM_W-1]};
      assign diff   = trial - {1'b0, d_i};
      assign ge     = trial >= {1'b0, d_i};
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            n_ff[k]   <= n_i << 1;
            d_ff[k]   <= d_i;
            q_ff[k]   <= {q_i[NUM_W-2:0], ge};
         end
      end
   end

   assign quo = q_ff[NUM_W-1];
endmodule

// ===== design/bsvf_sqrt.sv =====
`timescale 1ns / 1ps
// pipelined integer square root, floor of the root, one root bit per stage
// depends on bsvf_pkg
module bsvf_sqrt #(
   parameter int ROOT_W = 34
) (
   input  logic                clock,
   input  logic                en,
   input  logic [2*ROOT_W-1:0] rad,
   output logic [ROOT_W-1:0]   root
);
   import bsvf_pkg::*;

   localparam int XW = 2 * ROOT_W;
   localparam int RW = ROOT_W + 2;

   logic [RW-1:0]     rem_ff  [ROOT_W];
   logic [XW-1:0]     x_ff    [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [RW-1:0]     rem_i;
      logic [XW-1:0]     x_i;
      logic [ROOT_W-1:0] root_i;
      logic [RW+1:0]     trial;
      logic [RW+1:0]     cand;
      logic [RW+1:0]     diff;
      logic              ge;
      if (k == 0) begin : g_first
         assign rem_i  = '0;
         assign x_i    = rad;
         assign root_i = '0;
      end else begin : g_next
         assign rem_i  = rem_ff[k-1];
         assign x_i    = x_ff[k-1];
         assign root_i = root_ff[k-1];
      end
      assign trial = {rem_i, x_i[XW-1 -: SQRT_DIGIT_BITS]};
      assign cand  = {2'b00, root_i, SQRT_TRIAL_TAIL};
      assign diff  = trial - cand;
      assign ge    = trial >= cand;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
            x_ff[k]    <= x_i << SQRT_DIGIT_BITS;
            root_ff[k] <= {root_i[ROOT_W-2:0], ge};
         end
      end
   end

   assign root = root_ff[ROOT_W-1];
endmodule

// ===== design/bsvf_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the coefficient converter, bound to the top level
// depends on biquad_to_svf_coefficients_top
module bsvf_checker #(
   parameter int COEF_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COEF_WIDTH-1:0] rsp_gain_g,
   input logic [COEF_WIDTH-1:0] rsp_feedback_scale_h,
   input logic                  rsp_divide_fault
);
   // a waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   // a waiting result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_gain_g) && $stable(rsp_feedback_scale_h)
                                  && $stable(rsp_divide_fault))
      else $error("rsp item changed while stalled");

   // the input side only stalls behind a stalled result
   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req ready out of step with rsp side");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");
endmodule

bind biquad_to_svf_coefficients_top bsvf_checker #(.COEF_WIDTH(COEF_WIDTH)) u_bsvf_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_gain_g           (rsp_chan.gain_g),
   .rsp_feedback_scale_h (rsp_chan.feedback_scale_h),
   .rsp_divide_fault     (rsp_chan.divide_fault)
);
